// ----- rtl/ptfms_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptfms_pkg
// shared types and constants of the pulse trace filter and scaler
// ---------------------------------------------------------------------------
package ptfms_pkg;

    localparam int LINE_DEPTH     = 32;
    localparam int WINDOW_DEPTH   = 256;
    localparam int SCREEN_COLUMNS = 96;
    localparam int FIR_HALF       = 11;
    localparam int FIR_SHIFT      = 16;
    localparam int LEVEL_MAX      = 63;
    localparam int QUEUE_DEPTH    = 4;

    localparam int LINE_AW = $clog2(LINE_DEPTH);
    localparam int WIN_AW  = $clog2(WINDOW_DEPTH);
    localparam int COL_W   = 7;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // queue entry between the front and the back
    typedef struct packed {
        logic        removed;
        logic [15:0] sample;
    } t_cmd;

    // result item
    typedef struct packed {
        logic        event_res;
        logic        clear_screen;
        logic [6:0]  column;
        logic [5:0]  previous_level;
        logic [5:0]  level;
        logic [15:0] filtered_value;
        logic [15:0] window_low;
        logic [15:0] window_high;
    } t_res;

    function automatic logic [12:0] fir_tap(input logic [3:0] idx);
        case (idx)
            4'd0:    fir_tap = 13'd172;
            4'd1:    fir_tap = 13'd321;
            4'd2:    fir_tap = 13'd579;
            4'd3:    fir_tap = 13'd927;
            4'd4:    fir_tap = 13'd1360;
            4'd5:    fir_tap = 13'd1858;
            4'd6:    fir_tap = 13'd2390;
            4'd7:    fir_tap = 13'd2916;
            4'd8:    fir_tap = 13'd3391;
            4'd9:    fir_tap = 13'd3768;
            4'd10:   fir_tap = 13'd4012;
            4'd11:   fir_tap = 13'd4096;
            default: fir_tap = 13'd0;
        endcase
    endfunction

endpackage

// ----- rtl/ptfms_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptfms_ram
// single-port-write, registered-read generic ram
// ---------------------------------------------------------------------------
module ptfms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/ptfms_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptfms_front
// takes input transactions, tracks wake state, classifies samples and
// queues work for the back end
// ---------------------------------------------------------------------------
module ptfms_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_mode,
    input  logic [15:0]         i_sample,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output ptfms_pkg::t_cmd     o_cmd
);
    import ptfms_pkg::*;

    logic [15:0]  r_threshold;
    logic         r_tracking;
    t_cmd         r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic         w_push, w_pop, w_acc;
    t_cmd         w_cmd;

    assign o_ready = (r_cnt != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH)) ? 1'b1 : 1'b0;
    assign w_acc   = i_valid && o_ready;
    assign w_push  = w_acc && !i_mode && r_tracking;
    assign w_cmd.removed = (i_sample < r_threshold);
    assign w_cmd.sample  = i_sample;
    assign w_pop   = o_cmd_valid && i_cmd_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 16'd2000;
            r_tracking  <= 1'b0;
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
            if (w_acc && i_mode) begin
                r_tracking <= 1'b1;
            end else if (w_push && w_cmd.removed) begin
                r_tracking <= 1'b0;
            end
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(w_push) - (QUEUE_AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end
endmodule

// ----- rtl/ptfms_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptfms_back
// sequencer for fir, window min/max, level division and output register
// ---------------------------------------------------------------------------
module ptfms_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  ptfms_pkg::t_cmd     i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output ptfms_pkg::t_res     o_res
);
    import ptfms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FIR_RD, S_FIR_MUL, S_FIR_ACC, S_WIN_WR, S_WIN_RD, S_WIN_CMP,
        S_DIV_SETUP, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic [LINE_AW-1:0] r_line_pos;
    logic [LINE_AW:0]   r_line_fill;
    logic [WIN_AW-1:0]  r_win_pos;
    logic [WIN_AW:0]    r_win_fill;
    logic [5:0]         r_last_level;
    logic [COL_W-1:0]   r_draw_col;
    logic [15:0]        r_sample;

    // fir sequencing: step k 0..22 reads line_back(k)
    logic [4:0]   r_k;
    logic [33:0]  r_acc;
    logic [28:0]  r_prod;
    logic [15:0]  r_filt;
    logic [WIN_AW:0] r_i;
    logic [15:0]  r_lo, r_hi;
    logic         r_first;
    logic [21:0]  r_num;
    logic [15:0]  r_den;
    logic [5:0]   r_quo;
    logic [21:0]  r_rem;
    t_res         r_res;
    logic         r_valid;

    logic [LINE_AW-1:0] w_line_raddr;
    logic [15:0]        w_line_rdata, w_win_rdata;
    logic               w_line_we;
    logic [WIN_AW-1:0]  w_win_raddr;
    logic               w_win_we;
    logic [3:0]         w_tap_idx;
    logic [22:0]        w_rem_sh;

    assign w_line_raddr = r_line_pos - LINE_AW'(r_k);
    assign w_line_we    = (r_state == S_IDLE) && !r_valid && i_cmd_valid && !i_cmd.removed;
    assign w_win_we     = (r_state == S_WIN_WR);
    assign w_win_raddr  = r_i[WIN_AW-1:0];
    assign w_tap_idx    = (r_k > 5'd11) ? 4'(5'd22 - r_k) : r_k[3:0];
    assign w_rem_sh     = {r_rem, r_num[21]};

    ptfms_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_line (
        .i_clk(i_clk), .i_we(w_line_we), .i_waddr(r_line_pos),
        .i_wdata(i_cmd.sample), .i_raddr(w_line_raddr), .o_rdata(w_line_rdata)
    );

    // the filtered value is taken straight from the finished sum
    ptfms_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_window (
        .i_clk(i_clk), .i_we(w_win_we), .i_waddr(r_win_pos),
        .i_wdata(r_acc[FIR_SHIFT +: 16]), .i_raddr(w_win_raddr), .o_rdata(w_win_rdata)
    );

    assign o_cmd_ready = (r_state == S_IDLE) && !r_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_line_pos   <= '0;
            r_line_fill  <= '0;
            r_win_pos    <= '0;
            r_win_fill   <= '0;
            r_last_level <= '0;
            r_draw_col   <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && !r_valid) begin
                        if (i_cmd.removed) begin
                            r_line_pos  <= '0;
                            r_line_fill <= '0;
                            r_win_pos   <= '0;
                            r_win_fill  <= '0;
                            r_draw_col  <= '0;
                            // event_res and clear_screen set, all else zero
                            r_res       <= t_res'({1'b1, 1'b1, 67'd0});
                            r_valid     <= 1'b1;
                        end else if (r_line_fill != (LINE_AW+1)'(LINE_DEPTH)) begin
                            r_line_fill <= r_line_fill + 1'b1;
                            r_line_pos  <= r_line_pos + 1'b1;
                        end else begin
                            r_sample <= i_cmd.sample;
                            r_k      <= '0;
                            r_acc    <= '0;
                            r_state  <= S_FIR_RD;
                        end
                    end
                end
                S_FIR_RD: begin
                    // ram read in flight for line_back(r_k)
                    r_state <= S_FIR_MUL;
                end
                S_FIR_MUL: begin
                    // current sample written to the line ram in S_IDLE; bypass k=0
                    r_prod  <= 29'(fir_tap(w_tap_idx)) *
                               29'((r_k == 5'd0) ? r_sample : w_line_rdata);
                    r_state <= S_FIR_ACC;
                end
                S_FIR_ACC: begin
                    r_acc <= r_acc + 34'(r_prod);
                    if (r_k == 5'd22) begin
                        r_state <= S_WIN_WR;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_FIR_RD;
                    end
                end
                S_WIN_WR: begin
                    r_filt    <= r_acc[FIR_SHIFT +: 16];
                    r_state   <= S_WIN_RD;
                    r_i       <= '0;
                    r_first   <= 1'b1;
                end
                default: ;
            endcase
            // separate arms after filt is ready
            case (r_state)
                S_WIN_RD: begin
                    r_state <= S_WIN_CMP;
                end
                S_WIN_CMP: begin
                    if (r_first) begin
                        r_lo <= w_win_rdata;
                        r_hi <= w_win_rdata;
                        r_first <= 1'b0;
                    end else begin
                        if (w_win_rdata < r_lo) r_lo <= w_win_rdata;
                        if (w_win_rdata > r_hi) r_hi <= w_win_rdata;
                    end
                    if (r_i + 1'b1 >= r_win_fill) begin
                        r_state <= S_DIV_SETUP;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_WIN_RD;
                    end
                end
                S_DIV_SETUP: begin
                    r_num   <= 22'({6'd0, r_filt - r_lo} * 22'(LEVEL_MAX));
                    r_den   <= r_hi - r_lo;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle, 22 bits
                    if (w_rem_sh >= 23'(r_den)) begin
                        r_rem <= 22'(w_rem_sh - 23'(r_den));
                        r_quo <= {r_quo[4:0], 1'b1} | ((r_quo[5]) ? 6'h3F : 6'h00);
                    end else begin
                        r_rem <= w_rem_sh[21:0];
                        r_quo <= {r_quo[4:0], 1'b0} | ((r_quo[5]) ? 6'h3F : 6'h00);
                    end
                    r_num  <= {r_num[20:0], 1'b0};
                    if (r_k == 5'd0) begin
                        r_state <= S_OUT;
                    end
                    r_k <= r_k - 1'b1;
                end
                S_OUT: begin
                    r_res.event_res      <= 1'b0;
                    r_res.filtered_value <= r_filt;
                    r_res.window_low     <= r_lo;
                    r_res.window_high    <= r_hi;
                    r_res.previous_level <= r_last_level;
                    r_res.level          <= (r_den == '0) ? 6'd0 : r_quo;
                    r_last_level         <= (r_den == '0) ? 6'd0 : r_quo;
                    if (r_draw_col >= COL_W'(SCREEN_COLUMNS)) begin
                        r_res.clear_screen <= 1'b1;
                        r_res.column       <= '0;
                        r_draw_col         <= COL_W'(1);
                    end else begin
                        r_res.clear_screen <= 1'b0;
                        r_res.column       <= r_draw_col;
                        r_draw_col         <= r_draw_col + 1'b1;
                    end
                    r_line_pos <= r_line_pos + 1'b1;
                    r_valid    <= 1'b1;
                    r_state    <= S_IDLE;
                end
                S_WIN_WR: begin
                    r_win_pos <= r_win_pos + 1'b1;
                    if (r_win_fill != (WIN_AW+1)'(WINDOW_DEPTH)) begin
                        r_win_fill <= r_win_fill + 1'b1;
                    end
                end
                S_DIV_SETUP: ;
                default: ;
            endcase
            if (r_state == S_DIV_SETUP) begin
                r_k <= 5'd21;
            end
        end
    end
endmodule

// ----- rtl/pulse_trace_fir_minmax_scaler.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pulse_trace_fir_minmax_scaler
// pulse sensor trace: symmetric fir low-pass, sliding min/max, level scaling
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries sensor transactions: tuser = mode (1 = wake), tdata = sample
//   m_axis carries trace points or finger-removed events
//   i_cfg_we / i_cfg_wdata write the finger threshold (reset 2000)
// the front end tracks wake state, compares against the threshold and
// queues up to four commands; the back end runs one command at a time
// flow: a removal result passes through the queue and the back end's output
//   register; a line-fill sample is only written to the line ram; a trace
//   point runs the fir (23 taps, each read, multiplied and accumulated), a
//   scan of every filled window entry (up to 256, each read and compared),
//   the restoring divide and the output step, sequenced around the single
//   window ram read port and the shared multiplier; the back end takes no
//   new command until its result has been taken
// wake transactions and samples while idle give no result
// reset clears the queue, the fill, position and column counters and tracking; the stores need no clearing
// a stalled receiver holds the output register, the back end waits and
// the queue then fills before s_axis_tready drops
// ---------------------------------------------------------------------------
module pulse_trace_fir_minmax_scaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // raw_sample
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // clear_screen, column, previous_level,
                                        // level, filtered_value, window_low,
                                        // window_high, zero fill
    output logic        m_axis_tuser    // event_res
);
    import ptfms_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_ready;
    t_res w_res;

    ptfms_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_mode(s_axis_tuser), .i_sample(s_axis_tdata),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    ptfms_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tuser = w_res.event_res;
    assign m_axis_tdata = {4'd0, w_res.window_high, w_res.window_low,
                           w_res.filtered_value, w_res.level,
                           w_res.previous_level, w_res.column,
                           w_res.clear_screen};
endmodule
